// File: hw/rtl/bounded_deque_with_search_macros.svh
// Assertion macros used by the deque RTL.
`ifndef BOUNDED_DEQUE_WITH_SEARCH_MACROS_SVH
`define BOUNDED_DEQUE_WITH_SEARCH_MACROS_SVH

// Same-cycle implication, checked on clk outside of reset.
`define BDQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deque assertion failed");

// Next-cycle implication, checked on clk outside of reset.
`define BDQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deque assertion failed");

`endif

// File: hw/rtl/bdq_pkg.sv
// Types, constants and helpers for the bounded deque.
package bdq_pkg;

  localparam int CAPACITY = 16;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int WORD_W   = 32;
  localparam int REQ_W    = 3;
  localparam int ITEMS_W  = 5;

  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic signed [WORD_W-1:0] word_t;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_SEARCH     = 3'd4
  } req_code_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SEARCH,
    ST_RESP
  } bdq_state_t;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    word_t            word_in;
  } bdq_req_t;

  typedef struct packed {
    word_t              word_out;
    logic               found;
    logic               empty_error;
    logic               full_error;
    logic [ITEMS_W-1:0] items_held;
  } bdq_res_t;

  typedef struct packed {
    logic  we;
    addr_t waddr;
    word_t wdata;
    logic  re;
    addr_t raddr;
  } bdq_mem_req_t;

  // Ring slot of base + off, where base < CAPACITY and off <= CAPACITY.
  function automatic addr_t slot_add(addr_t base, cnt_t off);
    logic [CNT_W:0] sum;
    sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
    if (sum >= (CNT_W + 1)'(CAPACITY)) begin
      sum = sum - (CNT_W + 1)'(CAPACITY);
    end
    return ADDR_W'(sum);
  endfunction

endpackage

// File: hw/rtl/bounded_deque_with_search.sv
// Bounded double-ended queue of signed 32-bit words with search. Each transaction
// pushes at the front or back, pops from the front or back, or searches the
// stored words, and yields one result with the popped word, found flag, empty
// and full errors and the count held afterwards. Words live in a single-port-
// read ring memory; one transaction is worked at a time. A search reads the ring
// from the front through the memory read port, one entry per cycle, and stops at
// the first hit or after the last stored word.
// The output register holds a finished result while the next transaction is
// accepted.
`include "bounded_deque_with_search_macros.svh"

module bounded_deque_with_search
  import bdq_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  bdq_req_t in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output bdq_res_t out_data
);

  bdq_mem_req_t mem_req;
  word_t        mem_rdata;
  logic         res_valid;
  logic         res_take;
  bdq_res_t     res;

  bdq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  bdq_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (WORD_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

  // Load the output register whenever it is empty or being drained.
  assign res_take = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && res_valid) begin
      out_data <= res;
    end
  end

  `BDQ_ASSERT_NEXT(a_one_at_a_time, in_valid && !in_stall, in_stall)
  `BDQ_ASSERT_NOW(a_write_on_accept, mem_req.we, in_valid && !in_stall)
  `BDQ_ASSERT_NOW(a_no_read_with_write, mem_req.we, !mem_req.re)
  `BDQ_ASSERT_NOW(a_error_zero_word, out_valid && (out_data.empty_error || out_data.full_error),
                  out_data.word_out == '0 && !out_data.found)

endmodule

// File: hw/rtl/bdq_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
module bdq_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/bdq_ctrl.sv
// Request sequencer: ring pointers, memory access and the search walk.
module bdq_ctrl
  import bdq_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  input  bdq_req_t     in_data,
  output logic         res_valid,
  input  logic         res_take,
  output bdq_res_t     res,
  output bdq_mem_req_t mem_req,
  input  word_t        mem_rdata
);

  bdq_state_t state, state_next;
  addr_t      front, front_next;
  cnt_t       count, count_next;
  addr_t      idx, idx_next;
  bdq_req_t   cur, cur_next;
  bdq_res_t   res_next;

  logic is_full;
  logic is_empty;
  logic hit;
  logic last;

  assign is_full  = (count == CNT_W'(CAPACITY));
  assign is_empty = (count == '0);
  assign hit      = (mem_rdata == cur.word_in);
  assign last     = ((CNT_W'(idx) + CNT_W'(1)) == count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      front <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      front <= front_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    cur <= cur_next;
    res <= res_next;
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (in_data.req_type) inside
            REQ_POP_FRONT, REQ_POP_BACK: state_next = is_empty ? ST_RESP : ST_READ;
            REQ_SEARCH:                  state_next = is_empty ? ST_RESP : ST_SEARCH;
            default:                     state_next = ST_RESP;
          endcase
        end
      end
      ST_READ:   state_next = ST_RESP;
      ST_SEARCH: begin
        if (hit || last) begin
          state_next = ST_RESP;
        end
      end
      ST_RESP: begin
        if (res_take) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // Outputs, pointer updates and memory requests.
  always_comb begin
    front_next = front;
    count_next = count;
    idx_next   = idx;
    cur_next   = cur;
    res_next   = res;
    mem_req    = '0;
    in_stall   = (state != ST_IDLE);
    res_valid  = (state == ST_RESP);
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cur_next = in_data;
          res_next = '0;
          unique case (in_data.req_type)
            REQ_PUSH_FRONT: begin
              if (is_full) begin
                res_next.full_error = 1'b1;
              end else begin
                front_next    = (front == '0) ? ADDR_W'(CAPACITY - 1) : front - ADDR_W'(1);
                count_next    = count + CNT_W'(1);
                mem_req.we    = 1'b1;
                mem_req.waddr = front_next;
                mem_req.wdata = in_data.word_in;
              end
            end
            REQ_PUSH_BACK: begin
              if (is_full) begin
                res_next.full_error = 1'b1;
              end else begin
                count_next    = count + CNT_W'(1);
                mem_req.we    = 1'b1;
                mem_req.waddr = slot_add(front, count);
                mem_req.wdata = in_data.word_in;
              end
            end
            REQ_POP_FRONT: begin
              if (is_empty) begin
                res_next.empty_error = 1'b1;
              end else begin
                mem_req.re    = 1'b1;
                mem_req.raddr = front;
                front_next    = slot_add(front, CNT_W'(1));
                count_next    = count - CNT_W'(1);
              end
            end
            REQ_POP_BACK: begin
              if (is_empty) begin
                res_next.empty_error = 1'b1;
              end else begin
                mem_req.re    = 1'b1;
                mem_req.raddr = slot_add(front, count - CNT_W'(1));
                count_next    = count - CNT_W'(1);
              end
            end
            REQ_SEARCH: begin
              if (!is_empty) begin
                mem_req.re    = 1'b1;
                mem_req.raddr = front;
                idx_next      = '0;
              end
            end
            default: ;
          endcase
          res_next.items_held = ITEMS_W'(count_next);
        end
      end
      ST_READ: begin
        res_next.word_out = mem_rdata;
      end
      ST_SEARCH: begin
        // Compare the entry read last cycle; fetch the next one on a miss.
        if (hit) begin
          res_next.found = 1'b1;
        end else if (!last) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = slot_add(front, CNT_W'(idx) + CNT_W'(1));
          idx_next      = idx + ADDR_W'(1);
        end
      end
      ST_RESP: ;
      default: ;
    endcase
  end

endmodule
